// File: rtl/path_dot_segment_normalizer_unit_defines.svh
// -----------------------------------------------------------------------------
// Path dot-segment normalizer: assertion macros
// Concurrent check wrappers; define NO_ASSERTIONS to compile them out.
// -----------------------------------------------------------------------------
`ifndef PATH_DOT_SEGMENT_NORMALIZER_UNIT_DEFINES_SVH
`define PATH_DOT_SEGMENT_NORMALIZER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Plain invariant, sampled on every clock edge outside reset
`define PDSN_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication
`define PDSN_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PDSN_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PDSN_ASSERT_ALWAYS(name, expr, msg)
`define PDSN_ASSERT_IMPL(name, ante, cons, msg)
`define PDSN_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// File: rtl/pdsn_pkg.sv
// -----------------------------------------------------------------------------
// Path dot-segment normalizer package
// Request and status codes, characters, field widths and controller states.
// -----------------------------------------------------------------------------
package pdsn_pkg;

    localparam int PATH_BYTES_DEFAULT = 256;

    localparam int REQ_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 8;
    localparam int STATUS_W = 2;
    localparam int OLEN_W   = 8;

    localparam logic [REQ_W-1:0] REQ_BASE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PATH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ACCEPT    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd3;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CLOSE,
        S_DROP,
        S_TAIL,
        S_FIN,
        S_RESP
    } state_t;

endpackage

// File: rtl/path_dot_segment_normalizer_unit.sv
// -----------------------------------------------------------------------------
// Path dot-segment normalizer
// Builds a canonical slash-separated path in a byte buffer from streamed base
// and path bytes, removing empty, "." and ".." components.
// -----------------------------------------------------------------------------
//
//  channel   dir  tdata                                   tuser          tlast
//  s_axis    in   [7:0] byte_value, [15:8] read_index     [1:0] req_type last
//  m_axis    out  [7:0] result_length, [15:8] read_byte   [1:0] status   -
//
//  Base bytes, reads and inner path bytes pass through S_EXEC and S_RESP; the
//  first byte of a path starts the path in S_EXEC before the byte is handled,
//  and a byte that ends a component also passes S_CLOSE and S_FIN. A ".." pop
//  also walks the buffer back one byte per cycle through the single read port
//  of the buffer memory, then reads the new tail byte unless the pop lands on the root.
//  Reset clears control state only; the buffer needs no clearing pass.
//  One beat is in work at a time; a result waits in the output register and
//  the next beat is taken as soon as that register is free.
//
`include "path_dot_segment_normalizer_unit_defines.svh"

module path_dot_segment_normalizer_unit
    import pdsn_pkg::*;
#(
    parameter int PATH_BYTES = PATH_BYTES_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,   // [7:0] byte_value, [15:8] read_index
    input  logic [REQ_W-1:0]    s_axis_tuser,   // [1:0] req_type
    input  logic                s_axis_tlast,   // last

    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata,   // [7:0] result_length, [15:8] read_byte
    output logic [STATUS_W-1:0] m_axis_tuser    // [1:0] status
);

    localparam int LEN_W = $clog2(PATH_BYTES);
    localparam int CMP_W = (LEN_W > IDX_W) ? LEN_W : IDX_W;
    localparam logic [LEN_W:0]   PB_LIM  = (LEN_W+1)'(PATH_BYTES);
    localparam logic [LEN_W+1:0] PB_LIM2 = (LEN_W+2)'(PATH_BYTES);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

    // buffer memory
    logic [BYTE_W-1:0] canon_mem [PATH_BYTES];
    logic              mem_we;
    logic [LEN_W-1:0]  mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic [LEN_W-1:0]  mem_raddr;
    logic [BYTE_W-1:0] mem_rdata_reg;

    state_t state_reg, state_next;

    // captured beat
    logic [REQ_W-1:0]  req_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] keep_reg, keep_next;     // end of last non-slash base byte
    logic [LEN_W-1:0] comp_len_reg, comp_len_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic path_active_reg, path_active_next;
    logic path_failed_reg, path_failed_next;
    logic path_ended_reg, path_ended_next;
    logic path_empty_reg, path_empty_next;
    logic base_open_reg, base_open_next;
    logic base_ended_reg, base_ended_next;
    logic base_bad_reg, base_bad_next;
    logic tail_slash_reg, tail_slash_next;
    logic sep_reg, sep_next;
    logic dot0_reg, dot0_next;
    logic dot1_reg, dot1_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [BYTE_W-1:0]   rbyte_reg, rbyte_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [OLEN_W-1:0]   out_len_reg;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic                load_out;
    logic                in_fire;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_byte_reg, out_len_reg};
    assign m_axis_tuser  = out_status_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            canon_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= canon_mem[mem_raddr];
    end

    always_comb
    begin
        logic [LEN_W-1:0] l_len;
        logic [LEN_W-1:0] l_keep;
        logic             l_ended;
        logic             l_bad;
        logic             sep_now;
        logic [LEN_W:0]   wpos;
        logic [LEN_W+1:0] need;
        logic [LEN_W-1:0] pos_dec;

        l_len   = len_reg;
        l_keep  = keep_reg;
        l_ended = base_ended_reg;
        l_bad   = base_bad_reg;
        sep_now = sep_reg;
        wpos    = '0;
        need    = '0;
        pos_dec = pos_reg - LEN_ONE;

        state_next       = state_reg;
        len_next         = len_reg;
        keep_next        = keep_reg;
        comp_len_next    = comp_len_reg;
        pos_next         = pos_reg;
        path_active_next = path_active_reg;
        path_failed_next = path_failed_reg;
        path_ended_next  = path_ended_reg;
        path_empty_next  = path_empty_reg;
        base_open_next   = base_open_reg;
        base_ended_next  = base_ended_reg;
        base_bad_next    = base_bad_reg;
        tail_slash_next  = tail_slash_reg;
        sep_next         = sep_reg;
        dot0_next        = dot0_reg;
        dot1_next        = dot1_reg;
        status_next      = status_reg;
        rbyte_next       = rbyte_reg;

        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = CH_NUL;
        mem_raddr     = LEN_W'(s_axis_tdata[15:8]);
        s_axis_tready = 1'b0;
        load_out      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
            end

            S_EXEC:
            begin
                unique case (req_reg)
                    REQ_BASE:
                    begin
                        path_active_next = 1'b0;
                        if (!base_open_reg)
                        begin
                            l_len   = '0;
                            l_keep  = '0;
                            l_ended = 1'b0;
                            l_bad   = 1'b0;
                        end
                        if (!l_ended)
                        begin
                            if (byte_reg == CH_NUL)
                            begin
                                l_ended = 1'b1;
                            end
                            else if (({1'b0, l_len} + 1'b1) >= PB_LIM)
                            begin
                                l_bad = 1'b1;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = l_len;
                                mem_wdata = byte_reg;
                                l_len     = l_len + LEN_ONE;
                                if (byte_reg != CH_SLASH)
                                begin
                                    l_keep = l_len;
                                end
                            end
                        end
                        if (last_reg)
                        begin
                            // trailing slashes trimmed, never below one byte
                            if (l_len == '0)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = CH_SLASH;
                                l_len     = LEN_ONE;
                            end
                            else if (l_keep == '0)
                            begin
                                l_len = LEN_ONE;
                            end
                            else
                            begin
                                l_len = l_keep;
                            end
                            base_open_next  = 1'b0;
                            tail_slash_next = 1'b0;
                        end
                        else
                        begin
                            base_open_next = 1'b1;
                        end
                        len_next        = l_len;
                        keep_next       = l_keep;
                        base_ended_next = l_ended;
                        base_bad_next   = l_bad;
                        state_next      = S_RESP;
                    end

                    REQ_PATH:
                    begin
                        if (!path_active_reg)
                        begin
                            // path start; the byte itself is handled next cycle
                            path_active_next = 1'b1;
                            path_failed_next = 1'b0;
                            path_ended_next  = 1'b0;
                            path_empty_next  = 1'b0;
                            comp_len_next    = '0;
                            if (byte_reg == CH_NUL)
                            begin
                                path_empty_next = 1'b1;
                                path_ended_next = 1'b1;
                            end
                            else if (byte_reg == CH_SLASH)
                            begin
                                base_open_next = 1'b0;
                                mem_we         = 1'b1;
                                mem_waddr      = '0;
                                mem_wdata      = CH_SLASH;
                                len_next       = LEN_ONE;
                            end
                            else
                            begin
                                if (base_open_reg)
                                begin
                                    if (len_reg != '0)
                                    begin
                                        l_len = (keep_reg == '0) ? LEN_ONE : keep_reg;
                                    end
                                    tail_slash_next = 1'b0;
                                end
                                base_open_next = 1'b0;
                                if (l_len == '0)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = '0;
                                    mem_wdata = CH_SLASH;
                                    l_len     = LEN_ONE;
                                end
                                len_next = l_len;
                                if (base_bad_reg)
                                begin
                                    path_failed_next = 1'b1;
                                end
                            end
                            state_next = S_EXEC;
                        end
                        else if (!path_failed_reg && !path_ended_reg)
                        begin
                            if (byte_reg == CH_NUL)
                            begin
                                path_ended_next = 1'b1;
                                state_next      = S_CLOSE;
                            end
                            else if (byte_reg == CH_SLASH)
                            begin
                                state_next = S_CLOSE;
                            end
                            else if (({1'b0, comp_len_reg} + 1'b1) >= PB_LIM)
                            begin
                                path_failed_next = 1'b1;
                                state_next       = last_reg ? S_FIN : S_RESP;
                            end
                            else
                            begin
                                // component bytes go straight past the current end
                                if (comp_len_reg == '0)
                                begin
                                    sep_now   = (len_reg > LEN_ONE) && !tail_slash_reg;
                                    sep_next  = sep_now;
                                    dot0_next = (byte_reg == CH_DOT);
                                end
                                if (comp_len_reg == LEN_ONE)
                                begin
                                    dot1_next = (byte_reg == CH_DOT);
                                end
                                wpos = {1'b0, len_reg} + {1'b0, comp_len_reg}
                                     + {{LEN_W{1'b0}}, sep_now};
                                if (wpos < PB_LIM)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = wpos[LEN_W-1:0];
                                    mem_wdata = byte_reg;
                                end
                                comp_len_next = comp_len_reg + LEN_ONE;
                                state_next    = last_reg ? S_CLOSE : S_RESP;
                            end
                        end
                        else
                        begin
                            state_next = last_reg ? S_FIN : S_RESP;
                        end
                    end

                    REQ_READ:
                    begin
                        rbyte_next = (CMP_W'(idx_reg) < CMP_W'(len_reg)) ? mem_rdata_reg : CH_NUL;
                        state_next = S_RESP;
                    end

                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end

            S_CLOSE:
            begin
                comp_len_next = '0;
                state_next    = S_FIN;
                if ((comp_len_reg == '0) || ((comp_len_reg == LEN_ONE) && dot0_reg))
                begin
                    // empty or "." component: nothing to do
                end
                else if ((comp_len_reg == LEN_W'(2)) && dot0_reg && dot1_reg)
                begin
                    if (len_reg <= LEN_ONE)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = CH_SLASH;
                        len_next  = LEN_ONE;
                    end
                    else
                    begin
                        pos_next   = len_reg;
                        mem_raddr  = len_reg - LEN_ONE;
                        state_next = S_DROP;
                    end
                end
                else
                begin
                    need = {2'b00, len_reg} + {2'b00, comp_len_reg} + (LEN_W+2)'(1)
                         + {{(LEN_W+1){1'b0}}, (len_reg > LEN_ONE)};
                    if (need >= PB_LIM2)
                    begin
                        path_failed_next = 1'b1;
                    end
                    else
                    begin
                        if (sep_reg)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = len_reg;
                            mem_wdata = CH_SLASH;
                        end
                        len_next        = len_reg + comp_len_reg + LEN_W'(sep_reg);
                        tail_slash_next = 1'b0;
                    end
                end
            end

            S_DROP:
            begin
                // mem_rdata_reg holds the byte just below pos_reg
                if (mem_rdata_reg == CH_SLASH)
                begin
                    if (pos_reg <= LEN_ONE)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = '0;
                        mem_wdata  = CH_SLASH;
                        len_next   = LEN_ONE;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        len_next   = pos_dec;
                        mem_raddr  = pos_reg - LEN_W'(2);
                        state_next = S_TAIL;
                    end
                end
                else
                begin
                    pos_next = pos_dec;
                    if (pos_dec == '0)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = '0;
                        mem_wdata  = CH_SLASH;
                        len_next   = LEN_ONE;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        mem_raddr = pos_dec - LEN_ONE;
                    end
                end
            end

            S_TAIL:
            begin
                tail_slash_next = (mem_rdata_reg == CH_SLASH);
                state_next      = S_FIN;
            end

            S_FIN:
            begin
                if (last_reg)
                begin
                    path_active_next = 1'b0;
                    if (path_empty_reg)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else if (path_failed_reg)
                    begin
                        status_next = ST_TOO_LONG;
                        len_next    = '0;
                    end
                    else
                    begin
                        status_next = ST_OK;
                    end
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    load_out      = 1'b1;
                    s_axis_tready = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (in_fire)
        begin
            state_next  = S_EXEC;
            status_next = ST_ACCEPT;
            rbyte_next  = CH_NUL;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            len_reg         <= '0;
            keep_reg        <= '0;
            comp_len_reg    <= '0;
            pos_reg         <= '0;
            path_active_reg <= 1'b0;
            path_failed_reg <= 1'b0;
            path_ended_reg  <= 1'b0;
            path_empty_reg  <= 1'b0;
            base_open_reg   <= 1'b0;
            base_ended_reg  <= 1'b0;
            base_bad_reg    <= 1'b0;
            tail_slash_reg  <= 1'b0;
            sep_reg         <= 1'b0;
            dot0_reg        <= 1'b0;
            dot1_reg        <= 1'b0;
            status_reg      <= ST_ACCEPT;
            rbyte_reg       <= CH_NUL;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            len_reg         <= len_next;
            keep_reg        <= keep_next;
            comp_len_reg    <= comp_len_next;
            pos_reg         <= pos_next;
            path_active_reg <= path_active_next;
            path_failed_reg <= path_failed_next;
            path_ended_reg  <= path_ended_next;
            path_empty_reg  <= path_empty_next;
            base_open_reg   <= base_open_next;
            base_ended_reg  <= base_ended_next;
            base_bad_reg    <= base_bad_next;
            tail_slash_reg  <= tail_slash_next;
            sep_reg         <= sep_next;
            dot0_reg        <= dot0_next;
            dot1_reg        <= dot1_next;
            status_reg      <= status_next;
            rbyte_reg       <= rbyte_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // beat capture and result register
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg  <= s_axis_tuser;
            byte_reg <= s_axis_tdata[7:0];
            last_reg <= s_axis_tlast;
            idx_reg  <= s_axis_tdata[15:8];
        end
        if (load_out)
        begin
            out_status_reg <= status_reg;
            out_len_reg    <= OLEN_W'(len_reg);
            out_byte_reg   <= rbyte_reg;
        end
    end

    `PDSN_ASSERT_NEXT(a_fire_to_exec, in_fire, state_reg == S_EXEC, "accepted beat did not start work")
    `PDSN_ASSERT_IMPL(a_drop_pos, state_reg == S_DROP, (pos_reg != '0) && (pos_reg <= len_reg), "pop scan position out of range")
    `PDSN_ASSERT_NEXT(a_path_done, (state_reg == S_FIN) && last_reg, !path_active_reg, "path still active after final byte")
    `PDSN_ASSERT_ALWAYS(a_len_cap, {1'b0, len_reg} < PB_LIM, "buffer length beyond capacity")

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Path dot-segment normalizer testbench
// Streams base, path and read beats into the normalizer and checks every
// result beat against an in-bench model of the canonical path buffer. The
// run uses directed corner cases, then random path traffic under varying
// backpressure.
// ----------------------------------------------------------------------------
module tb;
    import pdsn_pkg::*;

    localparam int PATH_BYTES = PATH_BYTES_DEFAULT;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_BEATS = 1000;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;
    localparam int SQUEEZE_AT   = 300;
    localparam int SQUEEZE_LEN  = 250;

    typedef struct packed {
        logic [REQ_W-1:0] kind;
        logic [7:0]       ch;
        logic             last;
        logic [7:0]       idx;
    } beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [7:0]          length;
        logic [7:0]          rd;
    } reply_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata = '0;
    logic [REQ_W-1:0]    s_axis_tuser = '0;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [15:0]         m_axis_tdata;
    logic [STATUS_W-1:0] m_axis_tuser;

    beat_t  beat_q[$];
    reply_t replies_q[$];
    logic [7:0] text_q[$];
    beat_t  cur_beat = '0;
    int     beats_in = 0;
    int     hold_cnt = 0;
    bit     squeezed = 1'b0;
    int     quiet_cycles = 0;
    int     mismatches = 0;
    int     gen_count = 0;

    // model of the canonical buffer
    logic [7:0] cbuf [PATH_BYTES];
    logic [7:0] pbuf [PATH_BYTES];
    int clen = 0;
    int plen = 0;
    bit p_active = 0, p_failed = 0, p_ended = 0, p_empty = 0;
    bit b_open = 0, b_ended = 0, b_bad = 0;

    path_dot_segment_normalizer_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 clk = ~clk;

    // ---------------- canonical path model ----------------

    function automatic void set_root();
        cbuf[0] = CH_SLASH;
        clen = 1;
    endfunction

    function automatic void seal_base();
        if (clen == 0)
            set_root();
        else
            while (clen > 1 && cbuf[clen-1] == CH_SLASH)
                clen--;
        b_open = 0;
    endfunction

    function automatic void drop_tail_segment();
        int pos;
        if (clen <= 1)
        begin
            set_root();
            return;
        end
        pos = clen;
        while (pos > 0 && cbuf[pos-1] != CH_SLASH)
            pos--;
        if (pos <= 1)
            set_root();
        else
            clen = pos - 1;
    endfunction

    function automatic bit join_segment();
        int need;
        if (clen >= PATH_BYTES)
            return 0;
        need = clen + plen + 1;
        if (clen > 1)
            need++;
        if (need >= PATH_BYTES)
            return 0;
        if (clen > 1 && cbuf[clen-1] != CH_SLASH)
        begin
            cbuf[clen] = CH_SLASH;
            clen++;
        end
        for (int i = 0; i < plen; i++)
            cbuf[clen+i] = pbuf[i];
        clen += plen;
        return 1;
    endfunction

    function automatic bit close_component();
        bit ok;
        ok = 1;
        if (plen == 0 || (plen == 1 && pbuf[0] == CH_DOT))
            ok = 1;
        else if (plen == 2 && pbuf[0] == CH_DOT && pbuf[1] == CH_DOT)
            drop_tail_segment();
        else
            ok = join_segment();
        plen = 0;
        return ok;
    endfunction

    function automatic void feed_path_char(logic [7:0] ch);
        if (!p_active)
        begin
            p_active = 1;
            p_failed = 0;
            p_ended = 0;
            p_empty = 0;
            plen = 0;
            if (ch == CH_NUL)
            begin
                p_empty = 1;
                p_ended = 1;
                return;
            end
            if (ch == CH_SLASH)
            begin
                b_open = 0;
                set_root();
            end
            else
            begin
                if (b_open)
                    seal_base();
                if (clen == 0)
                    set_root();
                if (b_bad)
                begin
                    p_failed = 1;
                    return;
                end
            end
        end
        if (p_failed || p_ended)
            return;
        if (ch == CH_NUL)
        begin
            if (!close_component())
                p_failed = 1;
            p_ended = 1;
        end
        else if (ch == CH_SLASH)
        begin
            if (!close_component())
                p_failed = 1;
        end
        else if (plen + 1 >= PATH_BYTES)
            p_failed = 1;
        else
        begin
            pbuf[plen] = ch;
            plen++;
        end
    endfunction

    function automatic void normalize_step(beat_t b);
        logic [STATUS_W-1:0] status;
        logic [7:0]          rd;
        status = ST_ACCEPT;
        rd = '0;
        case (b.kind)
            REQ_BASE:
            begin
                p_active = 0;
                if (!b_open)
                begin
                    b_open = 1;
                    b_ended = 0;
                    b_bad = 0;
                    clen = 0;
                end
                if (!b_ended)
                begin
                    if (b.ch == CH_NUL)
                        b_ended = 1;
                    else if (clen + 1 >= PATH_BYTES)
                        b_bad = 1;
                    else
                    begin
                        cbuf[clen] = b.ch;
                        clen++;
                    end
                end
                if (b.last)
                    seal_base();
            end
            REQ_PATH:
            begin
                feed_path_char(b.ch);
                if (b.last)
                begin
                    if (p_empty)
                        status = ST_NOT_FOUND;
                    else
                    begin
                        if (!p_failed && !p_ended && !close_component())
                            p_failed = 1;
                        if (p_failed)
                        begin
                            status = ST_TOO_LONG;
                            clen = 0;
                        end
                        else
                        begin
                            if (clen == 0)
                                set_root();
                            status = ST_OK;
                        end
                    end
                    p_active = 0;
                end
            end
            REQ_READ:
            begin
                if (b.idx < clen)
                    rd = cbuf[b.idx];
            end
            default: ;
        endcase
        replies_q.push_back('{status, 8'(clen), rd});
    endfunction

    // ---------------- stimulus builders ----------------

    function automatic void add_beat(logic [REQ_W-1:0] kind, logic [7:0] ch, logic last,
                                     logic [7:0] idx);
        beat_q.push_back('{kind, ch, last, idx});
        if (kind != REQ_UNUSED)
            gen_count++;
    endfunction

    function automatic void add_text(logic [REQ_W-1:0] kind, string s);
        for (int i = 0; i < s.len(); i++)
            add_beat(kind, s[i], i == s.len() - 1, 8'($urandom_range(0, 255)));
    endfunction

    function automatic void emit_text(logic [REQ_W-1:0] kind, bit ends);
        for (int i = 0; i < text_q.size(); i++)
            add_beat(kind, text_q[i], ends && i == text_q.size() - 1,
                     8'($urandom_range(0, 255)));
    endfunction

    function automatic logic [7:0] name_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 8'h61 + 8'($urandom_range(0, 25));
            6:                return CH_DOT;
            default:          return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic void push_name(int n);
        for (int i = 0; i < n; i++)
            text_q.push_back(name_char());
    endfunction

    function automatic void make_base(bit force_long);
        int n;
        int nc;
        text_q.delete();
        if (force_long || $urandom_range(0, 79) == 0)
        begin
            n = $urandom_range(252, 262);
            for (int i = 0; i < n; i++)
                text_q.push_back((i % 9 == 0) ? CH_SLASH : 8'h61 + 8'(i % 26));
        end
        else if ($urandom_range(0, 9) == 0)
            text_q.push_back(CH_NUL);
        else
        begin
            if ($urandom_range(0, 9) < 7)
                text_q.push_back(CH_SLASH);
            nc = $urandom_range(0, 3);
            for (int c = 0; c < nc; c++)
            begin
                push_name($urandom_range(1, 4));
                if (c < nc - 1)
                    text_q.push_back(CH_SLASH);
            end
            repeat ($urandom_range(0, 2)) text_q.push_back(CH_SLASH);
            if (text_q.size() == 0)
                text_q.push_back(CH_NUL);
            else if ($urandom_range(0, 14) == 0)
                text_q.insert($urandom_range(0, text_q.size() - 1), CH_NUL);
        end
    endfunction

    function automatic void make_path(bit force_long);
        int nc;
        text_q.delete();
        if ($urandom_range(0, 19) == 0)
        begin
            text_q.push_back(CH_NUL);
            return;
        end
        if ($urandom_range(0, 1) == 1)
            text_q.push_back(CH_SLASH);
        nc = $urandom_range(0, 5);
        if (force_long && nc == 0)
            nc = 1;
        for (int c = 0; c < nc; c++)
        begin
            if ((force_long && c == 0) || $urandom_range(0, 99) == 0)
            begin
                repeat ($urandom_range(240, 258))
                    text_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
            end
            else
                case ($urandom_range(0, 9))
                    0: ;
                    1, 2: text_q.push_back(CH_DOT);
                    3, 4:
                    begin
                        text_q.push_back(CH_DOT);
                        text_q.push_back(CH_DOT);
                    end
                    5: repeat (3) text_q.push_back(CH_DOT);
                    default: push_name($urandom_range(1, 5));
                endcase
            if (c < nc - 1 || $urandom_range(0, 3) == 0)
                text_q.push_back(CH_SLASH);
        end
        if (text_q.size() == 0)
            text_q.push_back(CH_SLASH);
        else if ($urandom_range(0, 19) == 0)
            text_q.insert($urandom_range(0, text_q.size() - 1), CH_NUL);
    endfunction

    // ---------------- driver ----------------

    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        beat_t nxt;
        int    phase;
        bit    idle;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                normalize_step(cur_beat);
                beats_in <= beats_in + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                phase = (beats_in / 128) % 4;
                idle = (phase == 1 && $urandom_range(0, 99) < 71) ||
                       (phase == 3 && $urandom_range(0, 99) < 27);
                // keep offering beats while the output is held off
                if (hold_cnt != 0)
                    idle = 1'b0;
                if (beat_q.size() != 0 && !idle)
                begin
                    nxt = beat_q.pop_front();
                    cur_beat <= nxt;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {nxt.idx, nxt.ch};
                    s_axis_tuser <= nxt.kind;
                    s_axis_tlast <= nxt.last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk or negedge rst_n)
    begin : watch_proc
        reply_t want;
        int     phase;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (replies_q.size() == 0)
                begin
                    $error("result beat with nothing expected: status %0d length %0d byte %0d",
                           m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8]);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = replies_q.pop_front();
                    if (m_axis_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                        mismatches = mismatches + 1;
                    end
                    if (m_axis_tdata[7:0] !== want.length)
                    begin
                        $error("result_length: expected %0d, got %0d", want.length,
                               m_axis_tdata[7:0]);
                        mismatches = mismatches + 1;
                    end
                    if (m_axis_tdata[15:8] !== want.rd)
                    begin
                        $error("read_byte: expected %0d, got %0d", want.rd,
                               m_axis_tdata[15:8]);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (hold_cnt != 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cnt <= hold_cnt - 1;
            end
            else if (!squeezed && beats_in >= SQUEEZE_AT)
            begin
                squeezed <= 1'b1;
                hold_cnt <= SQUEEZE_LEN;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                phase = (beats_in / 128) % 4;
                m_axis_tready <= !((phase == 2 && $urandom_range(0, 99) < 71) ||
                                   (phase == 3 && $urandom_range(0, 99) < 27));
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ---------------- sequence ----------------

    initial
    begin : main_proc
        int seq_no;
        int r;
        seq_no = 0;

        // directed corner cases
        add_beat(REQ_UNUSED, 8'hFF, 1'b1, 8'hFF);
        add_beat(REQ_READ, CH_NUL, 1'b0, 8'h00);
        add_text(REQ_PATH, "b");            // relative path with no base loaded
        add_text(REQ_BASE, "/x//");         // trailing slashes trimmed
        add_text(REQ_PATH, "../..");        // pops stop at root
        add_beat(REQ_PATH, CH_NUL, 1'b1, 8'h00);
        add_beat(REQ_BASE, CH_NUL, 1'b1, 8'h00);
        add_beat(REQ_PATH, 8'h61, 1'b0, 8'h00);
        add_beat(REQ_PATH, CH_SLASH, 1'b0, 8'h00);
        add_beat(REQ_PATH, CH_NUL, 1'b0, 8'h00);
        add_beat(REQ_PATH, 8'hFF, 1'b1, 8'h00);
        add_beat(REQ_PATH, 8'h71, 1'b0, 8'h00);  // path cut short by a base beat
        add_beat(REQ_BASE, 8'h7A, 1'b1, 8'h00);
        add_text(REQ_PATH, "/.");
        add_beat(REQ_READ, 8'hFF, 1'b1, 8'hFF);
        add_beat(REQ_READ, CH_NUL, 1'b1, 8'h00);

        gen_count = 0;
        while (gen_count < RANDOM_BEATS)
        begin
            seq_no++;
            r = $urandom_range(0, 99);
            if (r < 5)
                add_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            else
            begin
                if (r < 35 || seq_no == 10)
                begin
                    make_base(seq_no == 10);
                    emit_text(REQ_BASE, $urandom_range(0, 9) != 0);
                end
                make_path(seq_no == 20 || seq_no == 35);
                emit_text(REQ_PATH, $urandom_range(0, 19) != 0);
                repeat ($urandom_range(0, 4))
                    add_beat(REQ_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'($urandom_range(0, 30)));
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (beat_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (replies_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && replies_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
